// ----- hw/rtl/bba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator: command and
// result items, status and register codes, back-end states.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BIT_W    = 5;
  localparam int unsigned BLK_W    = 17;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned MSIZE_W  = 11;
  localparam int unsigned BASE_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_SIZE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 1'b1;

  localparam logic [MSIZE_W-1:0] MAP_SIZE_RST = 11'd1024;

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FREED     = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_BAD   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [CNT_W-1:0]   want;
    logic [BLK_W-1:0]   blk;
  } cmd_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    status_e          status;
    logic             last;
  } res_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_LD,
    S_SCAN,
    S_ALLOC_WB,
    S_EXHAUST,
    S_FREE_RD,
    S_FREE_WB,
    S_RANGE
  } state_e;

endpackage

// ----- hw/rtl/bba_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bba_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_front
// Input side: accepts request items, saturates the request count, checks
// free requests against the map window and forms queue commands.
// ----------------------------------------------------------------------------
module bba_front
  import bba_pkg::*;
#(
  parameter int unsigned MAX_REQUEST = 63,
  parameter int unsigned SIZE_W      = 11
) (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic              s_axis_tuser,
  input  logic [23:0]       s_axis_tdata,
  input  logic [SIZE_W-1:0] eff_size_i,
  input  logic [BASE_W-1:0] base_offset_i,
  input  logic              back_ready_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output cmd_t              q_cmd_o
);

  logic             opcode;
  logic [CNT_W-1:0] count;
  logic [BLK_W-1:0] fblk;
  logic [BLK_W:0]   diff;
  logic             in_range;
  logic             drop;

  assign opcode = s_axis_tuser;
  assign count  = s_axis_tdata[5:0];
  assign fblk   = s_axis_tdata[22:6];

  assign diff     = {1'b0, fblk} - {2'b00, base_offset_i};
  assign in_range = !diff[BLK_W] && (diff[BLK_W-1:0] < BLK_W'(eff_size_i));

  // allocate of zero blocks has no effect and no result
  assign drop = !opcode && (count == '0);

  assign s_axis_tready = back_ready_i && !q_full_i;
  assign q_push_o      = s_axis_tvalid && s_axis_tready && !drop;

  always_comb begin
    q_cmd_o.blk  = fblk;
    q_cmd_o.want = (32'(count) > MAX_REQUEST) ? CNT_W'(MAX_REQUEST) : count;
    if (!opcode) begin
      q_cmd_o.kind = CMD_ALLOC;
    end else if (in_range) begin
      q_cmd_o.kind = CMD_FREE;
    end else begin
      q_cmd_o.kind = CMD_BAD;
    end
  end

endmodule

// ----- hw/rtl/bba_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_fifo
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module bba_fifo
  import bba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t       slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = !wptr_q;
    end
    if (pop_i) begin
      rptr_d = !rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hw/rtl/bba_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_back
// Execution side: clears the bitmap after reset, runs first-fit scans one
// map word at a time, clears bits on free and drives the result register.
// ----------------------------------------------------------------------------
module bba_back
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 1024,
  parameter int unsigned SIZE_W     = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] eff_size_i,
  input  logic [BASE_W-1:0] base_offset_i,
  input  logic              q_empty_i,
  input  cmd_t              q_cmd_i,
  output logic              q_pop_o,
  output logic              ready_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output res_t              res_o
);

  localparam int unsigned NWORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  state_e            state_q, state_d;
  logic [AW-1:0]     wa_q, wa_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [CNT_W-1:0]  got_q, got_d;
  logic [CNT_W-1:0]  want_q, want_d;
  logic              done_q, done_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic              ovalid_q, ovalid_d;
  res_t              out_q, out_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic              out_free;
  logic [31:0]       word_base;
  logic [31:0]       rem;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] avail;
  logic [BIT_W-1:0]  pos;
  logic              any;
  logic              grant_last;
  logic              more_words;
  logic [BLK_W:0]    grant_blk;
  logic [BLK_W-1:0]  fidx;
  logic [AW-1:0]     faddr;
  logic [BIT_W-1:0]  fbit;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (2 ** AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !ovalid_q || m_axis_tready;
  assign word_base = 32'(wa_q) * WORD_W;
  assign rem       = 32'(eff_size_i) - word_base;
  // bits past the map end count as used but keep their stored value
  assign mask      = (rem >= WORD_W) ? '1 : ((WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1));
  assign avail     = ~word_q & mask;

  always_comb begin
    pos = '0;
    any = 1'b0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pos = BIT_W'(i);
        any = 1'b1;
      end
    end
  end

  assign grant_last = ({1'b0, got_q} + 7'd1) == {1'b0, want_q};
  assign more_words = (word_base + WORD_W) < 32'(eff_size_i);
  assign grant_blk  = (BLK_W+1)'(word_base) + (BLK_W+1)'(pos) + (BLK_W+1)'(base_offset_i);
  assign fidx       = blk_q - BLK_W'(base_offset_i);
  assign faddr      = AW'(fidx >> BIT_W);
  assign fbit       = fidx[BIT_W-1:0];

  assign ready_o       = (state_q != S_INIT);
  assign m_axis_tvalid = ovalid_q;
  assign res_o         = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (clr_q == AW'(NWORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          case (q_cmd_i.kind)
            CMD_ALLOC: state_d = (eff_size_i == '0) ? S_EXHAUST : S_ALLOC_RD;
            CMD_FREE:  state_d = S_FREE_RD;
            default:   state_d = S_RANGE;
          endcase
        end
      end
      S_ALLOC_RD: state_d = S_ALLOC_LD;
      S_ALLOC_LD: state_d = S_SCAN;
      S_SCAN: begin
        if (!any) begin
          state_d = S_ALLOC_WB;
        end else if (out_free && grant_last) begin
          state_d = S_ALLOC_WB;
        end
      end
      S_ALLOC_WB: begin
        if (done_q) begin
          state_d = S_IDLE;
        end else if (more_words) begin
          state_d = S_ALLOC_RD;
        end else begin
          state_d = S_EXHAUST;
        end
      end
      S_EXHAUST: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_FREE_RD: state_d = S_FREE_WB;
      S_FREE_WB: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_RANGE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    wa_d      = wa_q;
    clr_d     = clr_q;
    got_d     = got_q;
    want_d    = want_q;
    done_d    = done_q;
    word_d    = word_q;
    blk_d     = blk_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    out_d     = out_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = wa_q;
    ram_raddr = wa_q;
    ram_wdata = word_q;
    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          wa_d    = '0;
          got_d   = '0;
          done_d  = 1'b0;
          want_d  = q_cmd_i.want;
          blk_d   = q_cmd_i.blk;
        end
      end
      S_ALLOC_RD: begin
        ram_re = 1'b1;
      end
      S_ALLOC_LD: begin
        word_d = ram_rdata;
      end
      S_SCAN: begin
        if (any && out_free) begin
          word_d[pos] = 1'b1;
          got_d       = got_q + CNT_W'(1);
          done_d      = grant_last;
          ovalid_d    = 1'b1;
          out_d.blk    = grant_blk[BLK_W-1:0];
          out_d.status = ST_GRANTED;
          out_d.last   = grant_last;
        end
      end
      S_ALLOC_WB: begin
        ram_we = 1'b1;
        if (!done_q && more_words) begin
          wa_d = wa_q + AW'(1);
        end
      end
      S_EXHAUST: begin
        if (out_free) begin
          ovalid_d     = 1'b1;
          out_d.blk    = '0;
          out_d.status = ST_EXHAUSTED;
          out_d.last   = 1'b1;
        end
      end
      S_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = faddr;
      end
      S_FREE_WB: begin
        if (out_free) begin
          ram_we       = 1'b1;
          ram_waddr    = faddr;
          ram_wdata    = ram_rdata & ~(WORD_W'(1) << fbit);
          ovalid_d     = 1'b1;
          out_d.blk    = blk_q;
          out_d.status = ST_FREED;
          out_d.last   = 1'b1;
        end
      end
      S_RANGE: begin
        if (out_free) begin
          ovalid_d     = 1'b1;
          out_d.blk    = blk_q;
          out_d.status = ST_RANGE;
          out_d.last   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      clr_q    <= '0;
      done_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q   <= wa_d;
    got_q  <= got_d;
    want_q <= want_d;
    word_q <= word_d;
    blk_q  <= blk_d;
    out_q  <= out_d;
  end

endmodule

// ----- hw/rtl/bitmap_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit bitmap block allocator with a front classifier, a two-entry
// command queue and a word-serial back end over a map RAM.
// ----------------------------------------------------------------------------
// After reset the map RAM is cleared one 32-bit word per cycle; no item is
// accepted during that pass, configuration writes are. An allocate item is
// dispatched from idle, then every map word the scan visits is read, loaded,
// scanned with one granted block per cycle while the output is free, and
// written back; a word that runs out of free bits before the request is met
// moves the scan on to the next word, and running past the map end gives an
// exhausted result. A free item reads the map word and writes it back with
// the bit cleared; an out-of-range free only returns its status. A stalled
// output holds the back end. Items are queued two deep so new
// requests are taken while the back end scans, and each request's results
// leave in order through an output register, the final one marked by tlast.
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS  = 1024,
  parameter int unsigned MAX_REQUEST = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BASE_W-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // opcode [0]
  input  logic                 s_axis_tuser,
  // request_count [5:0], free_block [22:6], zero [23]
  input  logic [23:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // block_number [16:0], zero [23:17]
  output logic [23:0]          m_axis_tdata,
  // status [1:0]
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int unsigned SIZE_W = $clog2(MAX_BLOCKS + 1);

  logic [MSIZE_W-1:0] map_size_q;
  logic [BASE_W-1:0]  base_offset_q;
  logic [SIZE_W-1:0]  eff_size;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_cmd_in, q_cmd_out;
  logic back_ready;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_q    <= MAP_SIZE_RST;
      base_offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_SIZE:    map_size_q    <= cfg_wdata_i[MSIZE_W-1:0];
        CFG_BASE_OFFSET: base_offset_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign eff_size = (32'(map_size_q) > MAX_BLOCKS) ? SIZE_W'(MAX_BLOCKS)
                                                    : SIZE_W'(map_size_q);

  bba_front #(
    .MAX_REQUEST (MAX_REQUEST),
    .SIZE_W      (SIZE_W)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .eff_size_i    (eff_size),
    .base_offset_i (base_offset_q),
    .back_ready_i  (back_ready),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd_in)
  );

  bba_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd_out)
  );

  bba_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_W     (SIZE_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eff_size_i    (eff_size),
    .base_offset_i (base_offset_q),
    .q_empty_i     (q_empty),
    .q_cmd_i       (q_cmd_out),
    .q_pop_o       (q_pop),
    .ready_o       (back_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = {7'b0, res.blk};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule
